@@ sv/sgtf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sgtf_pkg
// Shared types, sizes and helpers of the sensor grid trend fit block.
// ----------------------------------------------------------------------------
package sgtf_pkg;

	localparam int HISTORY_DEPTH = 3;
	localparam int GRID_SIZE     = 8;

	localparam int ROW_W   = 3;
	localparam int COL_W   = 3;
	localparam int RAW_W   = 10;
	localparam int LEVEL_W = 8;
	localparam int SLOPE_W = 9;
	localparam int ICPT_W  = 12;

	localparam int SQUARES = GRID_SIZE * GRID_SIZE;
	localparam int ADDR_W  = $clog2(SQUARES);
	localparam int HIST_W  = HISTORY_DEPTH * LEVEL_W;
	localparam int MOD_STEPS = (1 << ROW_W) / GRID_SIZE;

	localparam int FS_RESET  = 250;
	localparam int SCALE_MAX = 255;

	// least squares constants over positions 0..depth-1
	localparam int XS  = HISTORY_DEPTH * (HISTORY_DEPTH - 1) / 2;
	localparam int X2S = (HISTORY_DEPTH - 1) * HISTORY_DEPTH * (2 * HISTORY_DEPTH - 1) / 6;
	localparam int DEN = HISTORY_DEPTH * X2S - XS * XS;

	localparam int YS_W   = LEVEL_W + $clog2(HISTORY_DEPTH);
	localparam int XYS_W  = LEVEL_W + $clog2(XS + 1);
	localparam int SNUM_W = LEVEL_W + $clog2(HISTORY_DEPTH * XS + 1) + 1;

	// shared divider
	localparam int DIV_NW    = 20;
	localparam int DIV_DW    = 10;
	localparam int DIV_STEPS = 2;
	localparam int DIV_QW    = 12;
	localparam int NB_W      = $clog2(DIV_NW + 1);
	localparam int CNT_W     = $clog2(DIV_QW / DIV_STEPS + 1);

	localparam int SCALE_QB = ((LEVEL_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
	localparam int SLOPE_QB = ((SLOPE_W + 1 + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
	localparam int ICPT_QB  = ((ICPT_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
	localparam int SL_W     = SLOPE_QB + 1;
	localparam int INUM_W   = DIV_NW + 1;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
		logic [NB_W-1:0]   nbits;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_QW-1:0] quo;
	} div_rsp_t;

	function automatic logic [ADDR_W-1:0] sq_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		logic [ROW_W-1:0] r;
		logic [COL_W-1:0] c;
		r = row;
		c = col;
		for (int i = 0; i < MOD_STEPS; i++) begin
			if (int'(r) >= GRID_SIZE) r = r - ROW_W'(GRID_SIZE);
			if (int'(c) >= GRID_SIZE) c = c - COL_W'(GRID_SIZE);
		end
		return ADDR_W'(int'(r) * GRID_SIZE + int'(c));
	endfunction

endpackage
`default_nettype wire

@@ sv/sgtf_sample_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sgtf_sample_if
// Request channel carrying one raw sensor sample for one grid square.
// ----------------------------------------------------------------------------
interface sgtf_sample_if;
	import sgtf_pkg::*;

	logic               valid;
	logic               ready;
	logic [ROW_W-1:0]   row;
	logic [COL_W-1:0]   column;
	logic [RAW_W-1:0]   raw_level;
	logic               scan_start;

	modport source (output valid, row, column, raw_level, scan_start, input ready);
	modport sink (input valid, row, column, raw_level, scan_start, output ready);
endinterface
`default_nettype wire

@@ sv/sgtf_result_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sgtf_result_if
// Result channel with one square's scaled level, line fit and scan maximum.
// ----------------------------------------------------------------------------
interface sgtf_result_if;
	import sgtf_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [ROW_W-1:0]          out_row;
	logic [COL_W-1:0]          out_column;
	logic [LEVEL_W-1:0]        scaled_level;
	logic signed [SLOPE_W-1:0] slope;
	logic signed [ICPT_W-1:0]  intercept;
	logic [RAW_W-1:0]          max_level;

	modport source (output valid, out_row, out_column, scaled_level, slope, intercept,
		max_level, input ready);
	modport sink (input valid, out_row, out_column, scaled_level, slope, intercept,
		max_level, output ready);
endinterface
`default_nettype wire

@@ sv/sgtf_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sgtf_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module sgtf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ sv/sgtf_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sgtf_div
// Shared restoring divider, two quotient bits per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module sgtf_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sgtf_pkg::div_req_t req,
	output sgtf_pkg::div_rsp_t      rsp
);
	import sgtf_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_DW:0]   rem_q;
	logic [DIV_NW-1:0] sh_q;
	logic [DIV_QW-1:0] quo_q;
	logic [DIV_DW-1:0] den_q;

	logic [DIV_DW:0]   rem_c;
	logic [DIV_NW-1:0] sh_c;
	logic [DIV_QW-1:0] quo_c;
	logic [NB_W-1:0]   shamt;

	assign shamt = NB_W'(DIV_NW) - req.nbits;

	always_comb begin
		rem_c = rem_q;
		sh_c  = sh_q;
		quo_c = quo_q;
		for (int i = 0; i < DIV_STEPS; i++) begin
			rem_c = {rem_c[DIV_DW-1:0], sh_c[DIV_NW-1]};
			sh_c  = {sh_c[DIV_NW-2:0], 1'b0};
			if (rem_c >= {1'b0, den_q}) begin
				rem_c = rem_c - {1'b0, den_q};
				quo_c = {quo_c[DIV_QW-2:0], 1'b1};
			end else begin
				quo_c = {quo_c[DIV_QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(req.nbits / DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= (DIV_DW + 1)'(req.num >> req.nbits);
			sh_q  <= req.num << shamt;
			quo_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= rem_c;
			sh_q  <= sh_c;
			quo_q <= quo_c;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule
`default_nettype wire

@@ sv/sensor_grid_trend_fit.sv @@
`default_nettype none
// one sample at a time: a new request is taken only once the last result
// is loaded; the shared divider runs scale, slope and intercept in turn,
// plus one history read and one write back of the square's history memory
// reset clears control state, the max tracker, the history valid bits and
// sets full scale to 250; history entries read as zero until first written
// ----------------------------------------------------------------------------
// sensor_grid_trend_fit
// Scales light sensor samples, keeps a short history per grid square and
// fits a least squares line over it; tracks the scan maximum.
// ----------------------------------------------------------------------------
module sensor_grid_trend_fit (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	sgtf_sample_if.sink                   sample,
	sgtf_result_if.source                 result,
	input  wire logic                     cfg_wr_en,
	input  wire logic [sgtf_pkg::RAW_W-1:0] cfg_wr_data
);
	import sgtf_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCALE = 3'd1;
	localparam logic [2:0] ST_SUMS  = 3'd2;
	localparam logic [2:0] ST_SNUM  = 3'd3;
	localparam logic [2:0] ST_SLOPE = 3'd4;
	localparam logic [2:0] ST_INUM  = 3'd5;
	localparam logic [2:0] ST_ICPT  = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]         state_q;
	logic [RAW_W-1:0]   fs_q;
	logic [RAW_W-1:0]   scan_max_q;
	logic [SQUARES-1:0] vld_q;

	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               hit_q;
	logic [RAW_W-1:0]   max_q;
	logic [HIST_W-1:0]  hist_q;
	logic [LEVEL_W-1:0] scaled_q;
	logic [YS_W-1:0]    ys_q;
	logic [XYS_W-1:0]   xys_q;
	logic               neg_q;
	logic signed [SL_W-1:0] slope_full_q;
	logic [ICPT_W-1:0]  icpt_q;

	logic                      res_valid_q;
	logic [ROW_W-1:0]          res_row_q;
	logic [COL_W-1:0]          res_col_q;
	logic [LEVEL_W-1:0]        res_scaled_q;
	logic [SLOPE_W-1:0]        res_slope_q;
	logic [ICPT_W-1:0]         res_icpt_q;
	logic [RAW_W-1:0]          res_max_q;

	logic              accept;
	logic              out_load;
	logic              hist_we;
	logic [ADDR_W-1:0] rd_addr;
	logic [HIST_W-1:0] ram_rdata;
	logic [HIST_W-1:0] hist_new;
	logic [RAW_W-1:0]  fs_eff;
	logic [RAW_W-1:0]  clamped;
	logic [RAW_W-1:0]  max_next;
	logic [YS_W-1:0]   ys_c;
	logic [XYS_W-1:0]  xys_c;
	logic signed [SNUM_W-1:0] xys_x;
	logic signed [SNUM_W-1:0] ys_x;
	logic signed [SNUM_W-1:0] snum_c;
	logic [SNUM_W-1:0]        smag_c;
	logic signed [INUM_W-1:0] ys_i;
	logic signed [INUM_W-1:0] sl_i;
	logic signed [INUM_W-1:0] inum_c;
	logic [INUM_W-1:0]        imag_c;
	logic signed [SL_W-1:0]   sq_c;
	logic [ICPT_W-1:0]        iq_c;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign sample.ready = (state_q == ST_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign out_load     = (state_q == ST_DONE) && (!res_valid_q || result.ready);
	assign hist_we      = out_load;
	assign rd_addr      = sq_addr(sample.row, sample.column);

	assign fs_eff   = (fs_q == '0) ? RAW_W'(1) : fs_q;
	assign clamped  = (sample.raw_level > fs_eff) ? fs_eff : sample.raw_level;
	assign max_next = (sample.scan_start || sample.raw_level > scan_max_q) ?
		sample.raw_level : scan_max_q;

	assign hist_new = {(hit_q ? ram_rdata[HIST_W-LEVEL_W-1:0] : (HIST_W - LEVEL_W)'(0)),
		div_rsp.quo[LEVEL_W-1:0]};

	always_comb begin
		ys_c  = '0;
		xys_c = '0;
		for (int d = 0; d < HISTORY_DEPTH; d++) begin
			ys_c  = ys_c + YS_W'(hist_q[d*LEVEL_W +: LEVEL_W]);
			xys_c = xys_c + XYS_W'(d) * XYS_W'(hist_q[d*LEVEL_W +: LEVEL_W]);
		end
	end

	always_comb begin
		xys_x  = SNUM_W'(xys_q);
		ys_x   = SNUM_W'(ys_q);
		snum_c = xys_x * SNUM_W'(HISTORY_DEPTH) - ys_x * SNUM_W'(XS);
		smag_c = snum_c[SNUM_W-1] ? SNUM_W'(-snum_c) : SNUM_W'(snum_c);
		ys_i   = INUM_W'(ys_q);
		sl_i   = INUM_W'(slope_full_q);
		inum_c = ys_i - sl_i * INUM_W'(XS);
		imag_c = inum_c[INUM_W-1] ? INUM_W'(-inum_c) : INUM_W'(inum_c);
		sq_c   = SL_W'(div_rsp.quo[SLOPE_QB-1:0]);
		iq_c   = ICPT_W'(div_rsp.quo[ICPT_QB-1:0]);
	end

	always_comb begin
		div_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				div_req.start = accept;
				div_req.num   = DIV_NW'(clamped) * DIV_NW'(SCALE_MAX);
				div_req.den   = DIV_DW'(fs_eff);
				div_req.nbits = NB_W'(SCALE_QB);
			end
			ST_SNUM: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_NW'(smag_c);
				div_req.den   = DIV_DW'(DEN);
				div_req.nbits = NB_W'(SLOPE_QB);
			end
			ST_INUM: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_NW'(imag_c);
				div_req.den   = DIV_DW'(HISTORY_DEPTH);
				div_req.nbits = NB_W'(ICPT_QB);
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	sgtf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	sgtf_ram #(
		.WIDTH (HIST_W),
		.DEPTH (SQUARES)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (addr_q),
		.wdata (hist_q),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fs_q        <= RAW_W'(FS_RESET);
			scan_max_q  <= '0;
			vld_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) fs_q <= cfg_wr_data;
			if (out_load) begin
				res_valid_q   <= 1'b1;
				vld_q[addr_q] <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (accept) scan_max_q <= max_next;
			unique case (state_q)
				ST_IDLE:  if (accept) state_q <= ST_SCALE;
				ST_SCALE: if (div_rsp.done) state_q <= ST_SUMS;
				ST_SUMS:  state_q <= ST_SNUM;
				ST_SNUM:  state_q <= ST_SLOPE;
				ST_SLOPE: if (div_rsp.done) state_q <= ST_INUM;
				ST_INUM:  state_q <= ST_ICPT;
				ST_ICPT:  if (div_rsp.done) state_q <= ST_DONE;
				ST_DONE:  if (out_load) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// item registers
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q  <= sample.row;
			col_q  <= sample.column;
			addr_q <= rd_addr;
			hit_q  <= vld_q[rd_addr];
			max_q  <= max_next;
		end
		if (state_q == ST_SCALE && div_rsp.done) begin
			hist_q   <= hist_new;
			scaled_q <= div_rsp.quo[LEVEL_W-1:0];
		end
		if (state_q == ST_SUMS) begin
			ys_q  <= ys_c;
			xys_q <= xys_c;
		end
		if (state_q == ST_SNUM) neg_q <= snum_c[SNUM_W-1];
		if (state_q == ST_INUM) neg_q <= inum_c[INUM_W-1];
		if (state_q == ST_SLOPE && div_rsp.done) slope_full_q <= neg_q ? -sq_c : sq_c;
		if (state_q == ST_ICPT && div_rsp.done) icpt_q <= neg_q ? -iq_c : iq_c;
		if (out_load) begin
			res_row_q    <= row_q;
			res_col_q    <= col_q;
			res_scaled_q <= scaled_q;
			res_slope_q  <= slope_full_q[SLOPE_W-1:0];
			res_icpt_q   <= icpt_q;
			res_max_q    <= max_q;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.out_row      = res_row_q;
	assign result.out_column   = res_col_q;
	assign result.scaled_level = res_scaled_q;
	assign result.slope        = res_slope_q;
	assign result.intercept    = res_icpt_q;
	assign result.max_level    = res_max_q;

`ifndef ASSERT_OFF
	// history write back never collides with a new read
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		hist_we |-> !accept)
		else $error("history write overlaps a new request");

	// divider finishes only while the sequencer waits for it
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_SCALE || state_q == ST_SLOPE || state_q == ST_ICPT))
		else $error("divider result with no waiting step");

	// output slot is only loaded when free or being drained
	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!res_valid_q || result.ready))
		else $error("result overwritten before it was taken");

	// max tracker only grows within a scan
	a_max_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !sample.scan_start) |=> (scan_max_q >= $past(scan_max_q)))
		else $error("scan max decreased within a scan");
`endif
endmodule
`default_nettype wire

@@ test/sgtf_fit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgtf_fit_checker
// Watches the sample, result and full scale ports of the trend fit block.
// Keeps its own copy of every square's history, the scan maximum and the
// full scale. Predicts the scaled level, line fit and scan maximum for
// each accepted request, and compares each accepted result with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module sgtf_fit_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	sgtf_sample_if                          smp,
	sgtf_result_if                          res,
	input  wire logic                       cfg_wr_en,
	input  wire logic [sgtf_pkg::RAW_W-1:0] cfg_wr_data,
	output int                              fail_count,
	output int                              pending,
	output int                              fits_checked
);
	import sgtf_pkg::*;

	localparam int PRINT_CAP = 200;

	typedef struct packed {
		logic [ROW_W-1:0]          row;
		logic [COL_W-1:0]          column;
		logic [LEVEL_W-1:0]        level;
		logic signed [SLOPE_W-1:0] slope;
		logic signed [ICPT_W-1:0]  icpt;
		logic [RAW_W-1:0]          peak;
	} fit_t;

	logic [LEVEL_W-1:0] history [SQUARES][HISTORY_DEPTH];
	logic [RAW_W-1:0]   scan_peak;
	logic [RAW_W-1:0]   full_scale;
	fit_t               expected_fits[$];
	fit_t               seen_fit;
	fit_t               want_fit;
	int                 mismatches = 0;
	int                 checked = 0;
	int                 waiting = 0;

	assign fail_count   = mismatches;
	assign pending      = waiting;
	assign fits_checked = checked;

	task automatic report(input string field, input int want, input int got);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch at %0t ns: %s expected %0d got %0d", $time, field, want, got);
	endtask

	// shifts the new level into the square and fits a line over its history
	function automatic fit_t fit_square(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
			input logic [RAW_W-1:0] lvl, input logic st);
		fit_t f;
		int   sq;
		int   fs;
		int   v;
		int   xs;
		int   ys;
		int   x2s;
		int   xys;
		int   num;
		int   den;
		int   sl;
		int   ic;
		sq = (int'(r) % GRID_SIZE) * GRID_SIZE + int'(c) % GRID_SIZE;
		if (st)
			scan_peak = '0;
		if (lvl > scan_peak)
			scan_peak = lvl;
		fs = (full_scale == '0) ? 1 : int'(full_scale);
		v  = (int'(lvl) > fs) ? fs : int'(lvl);
		for (int d = HISTORY_DEPTH - 1; d > 0; d--)
			history[sq][d] = history[sq][d-1];
		history[sq][0] = LEVEL_W'(v * SCALE_MAX / fs);
		xs  = 0;
		ys  = 0;
		x2s = 0;
		xys = 0;
		for (int d = 0; d < HISTORY_DEPTH; d++) begin
			xs  += d;
			ys  += int'(history[sq][d]);
			x2s += d * d;
			xys += d * int'(history[sq][d]);
		end
		num = HISTORY_DEPTH * xys - xs * ys;
		den = HISTORY_DEPTH * x2s - xs * xs;
		sl  = (den != 0) ? num / den : 0;
		ic  = (ys - sl * xs) / HISTORY_DEPTH;
		f.row    = r;
		f.column = c;
		f.level  = history[sq][0];
		f.slope  = SLOPE_W'(sl);
		f.icpt   = ICPT_W'(ic);
		f.peak   = scan_peak;
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SQUARES; s++)
				for (int d = 0; d < HISTORY_DEPTH; d++)
					history[s][d] = '0;
			scan_peak  = '0;
			full_scale = RAW_W'(FS_RESET);
			expected_fits.delete();
			waiting = 0;
		end else begin
			if (res.valid === 1'b1 && res.ready === 1'b1) begin
				seen_fit.row    = res.out_row;
				seen_fit.column = res.out_column;
				seen_fit.level  = res.scaled_level;
				seen_fit.slope  = res.slope;
				seen_fit.icpt   = res.intercept;
				seen_fit.peak   = res.max_level;
				if (expected_fits.size() == 0) begin
					report("result with no request pending", 0, 0);
				end else begin
					want_fit = expected_fits.pop_front();
					checked++;
					if (seen_fit.row !== want_fit.row)
						report("out_row", int'(want_fit.row), int'(seen_fit.row));
					if (seen_fit.column !== want_fit.column)
						report("out_column", int'(want_fit.column), int'(seen_fit.column));
					if (seen_fit.level !== want_fit.level)
						report("scaled_level", int'(want_fit.level), int'(seen_fit.level));
					if (seen_fit.slope !== want_fit.slope)
						report("slope", int'(want_fit.slope), int'(seen_fit.slope));
					if (seen_fit.icpt !== want_fit.icpt)
						report("intercept", int'(want_fit.icpt), int'(seen_fit.icpt));
					if (seen_fit.peak !== want_fit.peak)
						report("max_level", int'(want_fit.peak), int'(seen_fit.peak));
				end
			end
			if (smp.valid === 1'b1 && smp.ready === 1'b1)
				expected_fits.push_back(fit_square(smp.row, smp.column, smp.raw_level,
					smp.scan_start));
			if (cfg_wr_en === 1'b1)
				full_scale = cfg_wr_data;
			waiting = expected_fits.size();
		end
	end

endmodule

@@ test/tb_sensor_grid_trend_fit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_grid_trend_fit
// Drives sensor samples into the trend fit block under a range of full scale
// settings: a directed set of extremes and trend shapes, then random phases
// with bursts of idle and stall on both channels; phases four and eight are calm.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sensor_grid_trend_fit;
	import sgtf_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 60;
	localparam int SETTLE_CYCLES = 30;
	localparam int RAW_MAX       = (1 << RAW_W) - 1;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [RAW_W-1:0] cfg_wr_data = '0;
	logic [RAW_W-1:0] cur_fs = RAW_W'(FS_RESET);
	int               fail_count;
	int               pending;
	int               fits_checked;
	int               cycles = 0;
	int               samples_sent = 0;
	int               settings_used = 0;
	int               gap_pct = 0;
	int               stall_pct = 0;
	int               phase_fs[RANDOM_PHASES] = '{1023, 0, 1, 517, 250, 0, 64, 1023};

	sgtf_sample_if sample_ch ();
	sgtf_result_if result_ch ();

	sensor_grid_trend_fit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (sample_ch),
		.result      (result_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	sgtf_fit_checker fit_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.smp          (sample_ch),
		.res          (result_ch),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.fits_checked (fits_checked)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results pending", cycles, pending);
			$display("simulation failed");
			$finish;
		end
	end

	// result side stalls in bursts
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				result_ch.ready = 1'b0;
				repeat ($urandom_range(1, 9) - 1) @(negedge clk);
			end else begin
				result_ch.ready = 1'b1;
			end
		end
	end

	task automatic send_sample(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
			input logic [RAW_W-1:0] lvl, input logic st);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			@(negedge clk);
			sample_ch.valid      = 1'b0;
			sample_ch.row        = ROW_W'($urandom);
			sample_ch.column     = COL_W'($urandom);
			sample_ch.raw_level  = RAW_W'($urandom);
			sample_ch.scan_start = 1'($urandom);
			repeat ($urandom_range(1, 9) - 1) @(negedge clk);
		end
		@(negedge clk);
		sample_ch.valid      = 1'b1;
		sample_ch.row        = r;
		sample_ch.column     = c;
		sample_ch.raw_level  = lvl;
		sample_ch.scan_start = st;
		@(posedge clk);
		while (sample_ch.ready !== 1'b1)
			@(posedge clk);
		samples_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		sample_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_full_scale(input int fs);
		drain();
		cfg_wr_en   = 1'b1;
		cfg_wr_data = RAW_W'(fs);
		cur_fs      = RAW_W'(fs);
		@(negedge clk);
		cfg_wr_en = 1'b0;
		settings_used++;
	endtask

	task automatic send_random_sample();
		logic [ROW_W-1:0] r;
		logic [COL_W-1:0] c;
		int               fs;
		int               lvl;
		fs = (cur_fs == '0) ? 1 : int'(cur_fs);
		// half the requests hit a few squares so their histories fill up
		if ($urandom_range(0, 1)) begin
			r = ROW_W'($urandom_range(0, 1) * 7);
			c = COL_W'($urandom_range(6, 7));
		end else begin
			r = ROW_W'($urandom_range(0, 7));
			c = COL_W'($urandom_range(0, 7));
		end
		case ($urandom_range(0, 3))
			0: lvl = int'($urandom_range(0, RAW_MAX));
			1: lvl = fs - 2 + int'($urandom_range(0, 4));
			2: lvl = $urandom_range(0, 1) ? RAW_MAX : 0;
			default: lvl = int'($urandom_range(0, fs));
		endcase
		if (lvl < 0)
			lvl = 0;
		if (lvl > RAW_MAX)
			lvl = RAW_MAX;
		send_sample(r, c, RAW_W'(lvl), $urandom_range(0, 7) == 0);
	endtask

	initial begin
		sample_ch.valid      = 1'b0;
		sample_ch.row        = '0;
		sample_ch.column     = '0;
		sample_ch.raw_level  = '0;
		sample_ch.scan_start = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: clamp, zero, trend shapes and corner squares at reset scale
		gap_pct   = 20;
		stall_pct = 20;
		send_sample(3'd0, 3'd0, 10'd0, 1'b1);
		send_sample(3'd0, 3'd0, 10'd1023, 1'b0);
		send_sample(3'd0, 3'd0, 10'd0, 1'b0);
		send_sample(3'd0, 3'd0, 10'd0, 1'b0);
		send_sample(3'd0, 3'd0, 10'd250, 1'b0);
		send_sample(3'd7, 3'd7, 10'd1023, 1'b1);
		send_sample(3'd7, 3'd7, 10'd1023, 1'b0);
		send_sample(3'd7, 3'd7, 10'd1023, 1'b0);
		send_sample(3'd7, 3'd0, 10'd125, 1'b0);
		send_sample(3'd0, 3'd7, 10'd249, 1'b0);
		send_sample(3'd3, 3'd5, 10'd251, 1'b0);
		// zero full scale acts as one
		write_full_scale(0);
		send_sample(3'd5, 3'd2, 10'd0, 1'b1);
		send_sample(3'd5, 3'd2, 10'd1, 1'b0);
		send_sample(3'd5, 3'd2, 10'd1023, 1'b0);
		write_full_scale(1023);
		send_sample(3'd2, 3'd6, 10'd1023, 1'b0);
		send_sample(3'd2, 3'd6, 10'd1022, 1'b0);
		send_sample(3'd2, 3'd6, 10'd512, 1'b1);
		send_sample(3'd2, 3'd6, 10'd1, 1'b0);
		write_full_scale(1);
		send_sample(3'd6, 3'd1, 10'd0, 1'b0);
		send_sample(3'd6, 3'd1, 10'd1, 1'b0);
		send_sample(3'd6, 3'd1, 10'd682, 1'b0);

		// random phases, each under its own full scale
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 4 || p == 6)
				write_full_scale(int'($urandom_range(2, RAW_MAX - 1)));
			else
				write_full_scale(phase_fs[p]);
			case (p)
				2: begin
					gap_pct   = 60;
					stall_pct = 60;
				end
				3, RANDOM_PHASES - 1: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
				default: begin
					gap_pct   = 25;
					stall_pct = 25;
				end
			endcase
			repeat (PHASE_ITEMS) send_random_sample();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("sent %0d samples under %0d full scale writes, %0d results compared",
			samples_sent, settings_used, fits_checked);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("simulation failed");
		end
		$finish;
	end

endmodule
